// File: rtl/core/tt_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table package
// Shared widths, operation and bound codes, and the entry and result types.
// ----------------------------------------------------------------------------
package tt_pkg;

    localparam int KEY_W   = 64;
    localparam int DEPTH_W = 6;
    localparam int SCORE_W = 16;
    localparam int BOUND_W = 2;
    localparam int MOVE_W  = 8;
    localparam int NIB_W   = 4;
    localparam int OP_W    = 2;

    // Operation codes.
    localparam logic [OP_W-1:0] OP_PROBE = 2'd0;
    localparam logic [OP_W-1:0] OP_SAVE  = 2'd1;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd2;

    // Bound kinds held in an entry.
    localparam logic [BOUND_W-1:0] BOUND_NONE  = 2'd0;
    localparam logic [BOUND_W-1:0] BOUND_EXACT = 2'd1;
    localparam logic [BOUND_W-1:0] BOUND_LOWER = 2'd2;
    localparam logic [BOUND_W-1:0] BOUND_UPPER = 2'd3;

    // Packed move value that stands for no move.
    localparam logic [MOVE_W-1:0] NO_MOVE = 8'hFF;

    // One stored table entry.
    typedef struct packed {
        logic [KEY_W-1:0]          key;
        logic [DEPTH_W-1:0]        depth;
        logic signed [SCORE_W-1:0] score;
        logic [BOUND_W-1:0]        bound;
        logic [MOVE_W-1:0]         move;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

    // One result transaction.
    typedef struct packed {
        logic                      key_hit;
        logic                      cutoff;
        logic signed [SCORE_W-1:0] cut_score;
        logic signed [SCORE_W-1:0] alpha_out;
        logic signed [SCORE_W-1:0] beta_out;
        logic                      move_found;
        logic [NIB_W-1:0]          found_row;
        logic [NIB_W-1:0]          found_col;
        logic                      entry_written;
    } t_result;

endpackage

// File: rtl/core/tt_ram.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Generic single-clock RAM
// One write port and one read port; the read data is registered.
// ----------------------------------------------------------------------------
module tt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_wr_addr,
    input  logic [WIDTH-1:0]         i_wr_data,
    input  logic [$clog2(DEPTH)-1:0] i_rd_addr,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write port and registered read port.
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        o_rd_data <= r_mem[i_rd_addr];
    end

endmodule

// File: rtl/core/transposition_table.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table
// Direct-mapped search-result store with depth-preferred replacement.
// ----------------------------------------------------------------------------
// A probe or a save runs as follows: the entry selected by the low
// INDEX_BITS bits of the key is read from the single entry RAM in the cycle
// of acceptance; then, in the evaluation state, once the result register is
// free, the result is registered and, for a save, the entry is written back
// through the same RAM. One item is in flight at a time, so a new
// transaction is taken only after the last has left the evaluation state. A
// clear walks the RAM one entry per cycle and then delivers its result;
// after reset the same sweep runs before the first item is accepted.
// ----------------------------------------------------------------------------
module transposition_table
    import tt_pkg::*;
#(
    parameter int INDEX_BITS = 16
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    // Input channel
    input  logic                      i_in_valid,
    output logic                      o_in_stall,
    input  logic [OP_W-1:0]           i_operation,
    input  logic [KEY_W-1:0]          i_position_key,
    input  logic [DEPTH_W-1:0]        i_search_depth,
    input  logic signed [SCORE_W-1:0] i_alpha_in,
    input  logic signed [SCORE_W-1:0] i_beta_in,
    input  logic signed [SCORE_W-1:0] i_score_in,
    input  logic [BOUND_W-1:0]        i_bound_kind,
    input  logic                      i_move_present,
    input  logic [NIB_W-1:0]          i_move_row,
    input  logic [NIB_W-1:0]          i_move_col,
    // Output channel
    output logic                      o_out_valid,
    input  logic                      i_out_stall,
    output logic                      o_key_hit,
    output logic                      o_cutoff,
    output logic signed [SCORE_W-1:0] o_cut_score,
    output logic signed [SCORE_W-1:0] o_alpha_out,
    output logic signed [SCORE_W-1:0] o_beta_out,
    output logic                      o_move_found,
    output logic [NIB_W-1:0]          o_found_row,
    output logic [NIB_W-1:0]          o_found_col,
    output logic                      o_entry_written
);

    localparam int DEPTH = 1 << INDEX_BITS;

    // Sequencer states.
    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_EVAL  = 2'd1;
    localparam logic [1:0] S_SWEEP = 2'd2;

    logic [1:0]                r_state;
    logic [INDEX_BITS-1:0]     r_sweep;
    logic                      r_report;
    logic                      r_out_valid;
    t_result                   r_res;

    // Latched transaction payload.
    logic [OP_W-1:0]           r_op;
    logic [KEY_W-1:0]          r_key;
    logic [DEPTH_W-1:0]        r_depth;
    logic signed [SCORE_W-1:0] r_alpha;
    logic signed [SCORE_W-1:0] r_beta;
    logic signed [SCORE_W-1:0] r_score;
    logic [BOUND_W-1:0]        r_bound;
    logic [MOVE_W-1:0]         r_move;

    logic                      in_acc;
    logic                      out_free;
    logic                      eval_go;
    logic                      save_ok;
    logic                      ram_we;
    logic [INDEX_BITS-1:0]     ram_wr_addr;
    logic [INDEX_BITS-1:0]     ram_rd_addr;
    t_entry                    ram_wr_data;
    t_entry                    rd_entry;
    t_entry                    new_entry;
    t_result                   n_res;

    // Handshake.
    assign in_acc     = i_in_valid && (r_state == S_IDLE);
    assign o_in_stall = (r_state != S_IDLE);
    assign out_free   = !r_out_valid || !i_out_stall;
    assign eval_go    = (r_state == S_EVAL) && out_free;

    // Entry store.
    tt_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (DEPTH)
    ) u_ram (
        .i_clk     (i_clk),
        .i_we      (ram_we),
        .i_wr_addr (ram_wr_addr),
        .i_wr_data (ram_wr_data),
        .i_rd_addr (ram_rd_addr),
        .o_rd_data (rd_entry)
    );

    // The read address follows the incoming key while idle and holds otherwise.
    assign ram_rd_addr = (r_state == S_IDLE) ? i_position_key[INDEX_BITS-1:0]
                                             : r_key[INDEX_BITS-1:0];

    // Replacement rule: empty slot, or new depth not below the stored one.
    assign save_ok = (rd_entry.key == '0) || (r_depth >= rd_entry.depth);

    assign new_entry.key   = r_key;
    assign new_entry.depth = r_depth;
    assign new_entry.score = r_score;
    assign new_entry.bound = r_bound;
    assign new_entry.move  = r_move;

    // Write port: clearing sweep or the write-back of a save.
    always_comb begin
        if (r_state == S_SWEEP) begin
            ram_we      = 1'b1;
            ram_wr_addr = r_sweep;
            ram_wr_data = '0;
        end else begin
            ram_we      = eval_go && (r_op == OP_SAVE) && save_ok;
            ram_wr_addr = r_key[INDEX_BITS-1:0];
            ram_wr_data = new_entry;
        end
    end

    // Result of the transaction from the entry that was read.
    always_comb begin
        logic                      hit;
        logic signed [SCORE_W-1:0] alpha;
        logic signed [SCORE_W-1:0] beta;
        hit   = (rd_entry.key == r_key);
        alpha = r_alpha;
        beta  = r_beta;
        n_res = '0;
        case (r_op)
            OP_PROBE: begin
                if (hit) begin
                    n_res.key_hit = 1'b1;
                    if (rd_entry.move != NO_MOVE) begin
                        n_res.move_found = 1'b1;
                        n_res.found_row  = rd_entry.move[MOVE_W-1:NIB_W];
                        n_res.found_col  = rd_entry.move[NIB_W-1:0];
                    end
                    if (rd_entry.depth >= r_depth) begin
                        if (rd_entry.bound == BOUND_EXACT) begin
                            n_res.cutoff    = 1'b1;
                            n_res.cut_score = rd_entry.score;
                        end else if (rd_entry.bound == BOUND_LOWER
                                     && rd_entry.score >= beta) begin
                            n_res.cutoff    = 1'b1;
                            n_res.cut_score = rd_entry.score;
                        end else if (rd_entry.bound == BOUND_UPPER
                                     && rd_entry.score <= alpha) begin
                            n_res.cutoff    = 1'b1;
                            n_res.cut_score = rd_entry.score;
                        end else begin
                            // Tighten the window, then check whether it closed.
                            if (rd_entry.bound == BOUND_LOWER && rd_entry.score > alpha) begin
                                alpha = rd_entry.score;
                            end
                            if (rd_entry.bound == BOUND_UPPER && rd_entry.score < beta) begin
                                beta = rd_entry.score;
                            end
                            if (alpha >= beta) begin
                                n_res.cutoff    = 1'b1;
                                n_res.cut_score = alpha;
                            end
                        end
                    end
                end
                n_res.alpha_out = alpha;
                n_res.beta_out  = beta;
            end
            OP_SAVE: begin
                n_res.entry_written = save_ok;
            end
            OP_CLEAR: begin
                n_res.entry_written = 1'b1;
            end
            default: begin
                n_res = '0;
            end
        endcase
    end

    // Sequencer.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_SWEEP;
            r_sweep  <= '0;
            r_report <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        if (i_operation == OP_CLEAR) begin
                            r_state  <= S_SWEEP;
                            r_sweep  <= '0;
                            r_report <= 1'b1;
                        end else begin
                            r_state <= S_EVAL;
                        end
                    end
                end
                S_EVAL: begin
                    if (out_free) begin
                        r_state <= S_IDLE;
                    end
                end
                S_SWEEP: begin
                    if (r_sweep == '1) begin
                        r_state  <= r_report ? S_EVAL : S_IDLE;
                        r_report <= 1'b0;
                    end else begin
                        r_sweep <= r_sweep + 1'b1;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Payload capture on acceptance.
    always_ff @(posedge i_clk) begin
        if (in_acc) begin
            r_op    <= i_operation;
            r_key   <= i_position_key;
            r_depth <= i_search_depth;
            r_alpha <= i_alpha_in;
            r_beta  <= i_beta_in;
            r_score <= i_score_in;
            r_bound <= i_bound_kind;
            r_move  <= i_move_present ? {i_move_row, i_move_col} : NO_MOVE;
        end
    end

    // Output register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (eval_go) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (eval_go) begin
            r_res <= n_res;
        end
    end

    assign o_out_valid     = r_out_valid;
    assign o_key_hit       = r_res.key_hit;
    assign o_cutoff        = r_res.cutoff;
    assign o_cut_score     = r_res.cut_score;
    assign o_alpha_out     = r_res.alpha_out;
    assign o_beta_out      = r_res.beta_out;
    assign o_move_found    = r_res.move_found;
    assign o_found_row     = r_res.found_row;
    assign o_found_col     = r_res.found_col;
    assign o_entry_written = r_res.entry_written;

endmodule

// File: rtl/core/tt_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Transposition table checker
// Port-level assertions on the table, attached to the top level by bind.
// ----------------------------------------------------------------------------
module tt_checker
    import tt_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_in_valid,
    input  logic                      o_in_stall,
    input  logic [OP_W-1:0]           i_operation,
    input  logic [KEY_W-1:0]          i_position_key,
    input  logic [DEPTH_W-1:0]        i_search_depth,
    input  logic signed [SCORE_W-1:0] i_alpha_in,
    input  logic signed [SCORE_W-1:0] i_beta_in,
    input  logic signed [SCORE_W-1:0] i_score_in,
    input  logic [BOUND_W-1:0]        i_bound_kind,
    input  logic                      i_move_present,
    input  logic [NIB_W-1:0]          i_move_row,
    input  logic [NIB_W-1:0]          i_move_col,
    input  logic                      o_out_valid,
    input  logic                      i_out_stall,
    input  logic                      o_key_hit,
    input  logic                      o_cutoff,
    input  logic signed [SCORE_W-1:0] o_cut_score,
    input  logic signed [SCORE_W-1:0] o_alpha_out,
    input  logic signed [SCORE_W-1:0] o_beta_out,
    input  logic                      o_move_found,
    input  logic [NIB_W-1:0]          o_found_row,
    input  logic [NIB_W-1:0]          o_found_col,
    input  logic                      o_entry_written
);

    // A stalled request transaction holds its valid and its fields.
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && o_in_stall |=> i_in_valid && $stable(i_operation)
            && $stable(i_position_key) && $stable(i_search_depth)
            && $stable(i_alpha_in) && $stable(i_beta_in) && $stable(i_score_in)
            && $stable(i_bound_kind) && $stable(i_move_present)
            && $stable(i_move_row) && $stable(i_move_col))
        else $error("stalled request transaction changed");

    // A stalled result transaction holds its valid and its fields.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid && $stable(o_key_hit)
            && $stable(o_cutoff) && $stable(o_cut_score) && $stable(o_alpha_out)
            && $stable(o_beta_out) && $stable(o_move_found)
            && $stable(o_found_row) && $stable(o_found_col)
            && $stable(o_entry_written))
        else $error("stalled result transaction changed");

    // Only one transaction is in flight: the input stalls after an acceptance.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && !o_in_stall |=> o_in_stall)
        else $error("input accepted while a transaction is in flight");

    // A cutoff or a found move is only reported on a key hit.
    a_cut_needs_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && (o_cutoff || o_move_found) |-> o_key_hit)
        else $error("cutoff or move reported without a key hit");

    // Save and clear results never carry probe information.
    a_write_no_probe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_entry_written |-> !o_key_hit && !o_cutoff)
        else $error("write result carries probe fields");

endmodule

bind transposition_table tt_checker u_tt_checker (.*);
